// ===== design/mffd_pkg.sv =====
// shared types and constants for the motor feedback frame decoder
// no dependencies

package mffd_pkg;

  localparam int unsigned CountW   = 13;
  localparam int unsigned SpeedW   = 16;
  localparam int unsigned CurW     = 16;
  localparam int unsigned TempW    = 8;
  localparam int unsigned GainW    = 32;
  localparam int unsigned StepW    = 45;
  localparam int unsigned AngleW   = 64;
  localparam int unsigned CurMaW   = 17;
  localparam int unsigned InDataW  = 56;
  localparam int unsigned OutDataW = 168;
  localparam int unsigned AddrW    = 4;

  localparam logic signed [13:0] TurnCounts = 14'sd8191;
  localparam logic signed [13:0] HalfTurnHi = 14'sd4096;
  localparam logic signed [13:0] HalfTurnLo = -14'sd4096;
  localparam logic signed [25:0] MaScale    = 26'sd625;
  localparam int unsigned        MaShift    = 9;

  localparam logic [1:0] RegAngleGain = 2'd0;
  localparam logic [1:0] RegHotOn     = 2'd1;
  localparam logic [1:0] RegHotOff    = 2'd2;

  localparam logic [GainW-1:0] GainReset   = 32'd9935693;
  localparam logic [TempW-1:0] HotOnReset  = 8'd80;
  localparam logic [TempW-1:0] HotOffReset = 8'd70;

  typedef struct packed {
    logic signed [GainW-1:0] angle_gain;
    logic [TempW-1:0]        hot_on;
    logic [TempW-1:0]        hot_off;
  } cfg_t;

  typedef struct packed {
    logic signed [CountW-1:0] delta;
    logic [CountW-1:0]        count;
    logic [SpeedW-1:0]        speed;
    logic signed [CurW-1:0]   current;
    logic [TempW-1:0]         temp;
    logic                     hot;
  } front_t;

  typedef struct packed {
    logic signed [StepW-1:0]  step;
    logic [CountW-1:0]        count;
    logic [SpeedW-1:0]        speed;
    logic signed [CurMaW-1:0] current_ma;
    logic [TempW-1:0]         temp;
    logic                     hot;
  } scaled_t;

endpackage

// ===== design/mffd_regs.sv =====
// configuration registers behind the apb-style port
// depends on mffd_pkg

module mffd_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mffd_pkg::AddrW-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output mffd_pkg::cfg_t              cfg_o
);
  import mffd_pkg::*;

  cfg_t       cfg_q;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.angle_gain <= GainReset;
      cfg_q.hot_on     <= HotOnReset;
      cfg_q.hot_off    <= HotOffReset;
    end else if (wr_en) begin
      unique case (reg_idx)
        RegAngleGain: cfg_q.angle_gain <= pwdata;
        RegHotOn:     cfg_q.hot_on     <= pwdata[TempW-1:0];
        RegHotOff:    cfg_q.hot_off    <= pwdata[TempW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegAngleGain: prdata = cfg_q.angle_gain;
      RegHotOn:     prdata = {24'd0, cfg_q.hot_on};
      RegHotOff:    prdata = {24'd0, cfg_q.hot_off};
      default:      prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ===== design/mffd_front.sv =====
// input stage: count unwrap against the previous frame and overheat hysteresis
// depends on mffd_pkg

module mffd_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  output logic                        ready_o,
  input  logic [mffd_pkg::CountW-1:0] count_i,
  input  logic [mffd_pkg::SpeedW-1:0] speed_i,
  input  logic [mffd_pkg::CurW-1:0]   current_i,
  input  logic [mffd_pkg::TempW-1:0]  temp_i,
  input  mffd_pkg::cfg_t              cfg_i,
  output logic                        valid_o,
  input  logic                        ready_i,
  output mffd_pkg::front_t            data_o
);
  import mffd_pkg::*;

  logic              valid_q;
  front_t            data_q, data_d;
  logic [CountW-1:0] prev_q;
  logic              first_q;
  logic              hot_q, hot_d;
  logic              accept;
  logic signed [13:0] diff, diff_adj;

  assign ready_o = !valid_q || ready_i;
  assign accept  = valid_i && ready_o;

  always_comb begin
    diff = $signed({1'b0, count_i}) - $signed({1'b0, prev_q});
    if (first_q) begin
      diff_adj = 14'sd0;
    end else if (diff >= HalfTurnHi) begin
      diff_adj = diff - TurnCounts;
    end else if (diff <= HalfTurnLo) begin
      diff_adj = diff + TurnCounts;
    end else begin
      diff_adj = diff;
    end

    if (temp_i >= cfg_i.hot_on) begin
      hot_d = 1'b1;
    end else if (temp_i <= cfg_i.hot_off) begin
      hot_d = 1'b0;
    end else begin
      hot_d = hot_q;
    end

    data_d.delta   = diff_adj[CountW-1:0];
    data_d.count   = count_i;
    data_d.speed   = speed_i;
    data_d.current = current_i;
    data_d.temp    = temp_i;
    data_d.hot     = hot_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      prev_q  <= '0;
      first_q <= 1'b1;
      hot_q   <= 1'b0;
    end else begin
      if (ready_o) begin
        valid_q <= valid_i;
      end
      if (accept) begin
        prev_q  <= count_i;
        first_q <= 1'b0;
        hot_q   <= hot_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

  a_first_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && first_q) |=> (data_q.delta == '0))
    else $error("first frame delta not zero");

  a_delta_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (data_q.delta >= -13'sd4095))
    else $error("unwrapped delta out of range");

  a_hot_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (temp_i >= cfg_i.hot_on)) |=> hot_q)
    else $error("overheat flag not set");

endmodule

// ===== design/mffd_scale.sv =====
// multiply stage: delta times angle gain, current scaled to milliamps
// depends on mffd_pkg

module mffd_scale (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  output logic                         ready_o,
  input  mffd_pkg::front_t             data_i,
  input  logic signed [mffd_pkg::GainW-1:0] gain_i,
  output logic                         valid_o,
  input  logic                         ready_i,
  output mffd_pkg::scaled_t            data_o
);
  import mffd_pkg::*;

  logic              valid_q;
  scaled_t           data_q, data_d;
  logic signed [25:0] cur_prod;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    cur_prod          = 26'(data_i.current) * MaScale;
    data_d.step       = 45'(data_i.delta) * 45'(gain_i);
    data_d.count      = data_i.count;
    data_d.speed      = data_i.speed;
    data_d.current_ma = cur_prod[25:MaShift];
    data_d.temp       = data_i.temp;
    data_d.hot        = data_i.hot;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== design/mffd_accum.sv =====
// output stage: 64-bit angle accumulator and result register
// depends on mffd_pkg

module mffd_accum (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  output logic                         ready_o,
  input  mffd_pkg::scaled_t            data_i,
  output logic                         valid_o,
  input  logic                         ready_i,
  output logic [mffd_pkg::AngleW-1:0]  total_o,
  output mffd_pkg::scaled_t            data_o
);
  import mffd_pkg::*;

  logic              valid_q;
  logic [AngleW-1:0] accum_q, accum_d;
  scaled_t           data_q;
  logic              load;

  assign ready_o = !valid_q || ready_i;
  assign load    = ready_o && valid_i;
  assign accum_d = accum_q + AngleW'(data_i.step);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      accum_q <= '0;
    end else begin
      if (ready_o) begin
        valid_q <= valid_i;
      end
      if (load) begin
        accum_q <= accum_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign total_o = accum_q;
  assign data_o  = data_q;

  a_accum_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> (accum_q == $past(accum_d)))
    else $error("accumulator did not take the step");

  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> valid_q)
    else $error("loaded result not presented");

  a_hold_accum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !load |=> $stable(accum_q))
    else $error("accumulator moved without a transaction");

endmodule

// ===== design/motor_feedback_frame_decoder.sv =====
// top level of the motor feedback frame decoder
// depends on mffd_pkg, mffd_regs, mffd_front, mffd_scale, mffd_accum
//
// channel     dir  handshake                    payload
// s_axis      in   tvalid/tready                tdata 56 bits, feedback frame
// m_axis      out  tvalid/tready                tdata 168 bits, decoded result
// apb         in   psel/penable/pwrite/pready   3 registers at 0x0, 0x4, 0x8
//
// one frame per cycle sustained while m_axis_tready stays high; three register
// stages (unwrap, multiply, accumulate) carry each frame to the output in turn
// each stage has its own valid bit, so a stalled output fills the pipe
// before s_axis_tready drops
// reset clears valids, previous count, overheat flag and accumulator and sets
// the first-frame mark; registers return to their defaults

module motor_feedback_frame_decoder (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // encoder_count, speed_word, current_word, temperature
  input  logic [mffd_pkg::InDataW-1:0]  s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // total_angle, step_angle, position_count, speed_rpm, current_ma, temp_out,
  // overheated
  output logic [mffd_pkg::OutDataW-1:0] m_axis_tdata,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mffd_pkg::AddrW-1:0]    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import mffd_pkg::*;

  cfg_t              cfg;
  front_t            front;
  scaled_t           scaled, result;
  logic              front_valid, front_ready;
  logic              scale_valid, scale_ready;
  logic [AngleW-1:0] total;

  mffd_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  mffd_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s_axis_tvalid),
    .ready_o   (s_axis_tready),
    .count_i   (s_axis_tdata[12:0]),
    .speed_i   (s_axis_tdata[28:13]),
    .current_i (s_axis_tdata[44:29]),
    .temp_i    (s_axis_tdata[52:45]),
    .cfg_i     (cfg),
    .valid_o   (front_valid),
    .ready_i   (front_ready),
    .data_o    (front)
  );

  mffd_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (front_valid),
    .ready_o (front_ready),
    .data_i  (front),
    .gain_i  (cfg.angle_gain),
    .valid_o (scale_valid),
    .ready_i (scale_ready),
    .data_o  (scaled)
  );

  mffd_accum u_accum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (scale_valid),
    .ready_o (scale_ready),
    .data_i  (scaled),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .total_o (total),
    .data_o  (result)
  );

  assign m_axis_tdata = {4'd0, result.hot, result.temp, result.current_ma,
                         result.speed, result.count, result.step, total};

endmodule
